/* src/bsrd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bsrd_pkg;

   localparam int MAX_BITS   = 65536;
   localparam int BLOCK_BITS = 32;
   localparam int WORD_CNT   = MAX_BITS / BLOCK_BITS;
   localparam int WORD_AW    = $clog2(WORD_CNT);
   localparam int WIDX_W     = WORD_AW + 1;
   localparam int TBL_DEPTH  = WORD_CNT + 1;
   localparam int TBL_AW     = $clog2(TBL_DEPTH);
   localparam int CNT_W      = 17;
   localparam int FACT_W     = 7;
   localparam int POS_W      = 17;
   localparam int BIDX_W     = 13;
   localparam int BYTE_W     = 8;
   localparam int LANES      = BLOCK_BITS / BYTE_W;
   localparam int LANE_W     = $clog2(LANES);
   localparam int BITSEL_W   = $clog2(BLOCK_BITS);
   localparam int POPC_W     = $clog2(BLOCK_BITS) + 1;
   localparam int DIV_STEPS  = WIDX_W;
   localparam int STEP_W     = $clog2(DIV_STEPS);

   localparam logic [FACT_W-1:0] DEF_FACTOR = FACT_W'(4);
   localparam logic [CNT_W-1:0]  LEN_MAX    = CNT_W'(MAX_BITS);

   localparam logic [1:0] MODE_WRITE = 2'd0;
   localparam logic [1:0] MODE_BUILD = 2'd1;
   localparam logic [1:0] MODE_ONES  = 2'd2;
   localparam logic [1:0] MODE_ZEROS = 2'd3;

   localparam logic CSR_FACTOR = 1'b0;
   localparam logic CSR_LENGTH = 1'b1;

   typedef logic [BLOCK_BITS-1:0] word_type;

   function automatic logic [POPC_W-1:0] popcount32(input word_type w);
      logic [POPC_W-1:0] c;
      c = '0;
      for (int k = 0; k < BLOCK_BITS; k++) begin
         c = c + POPC_W'(w[k]);
      end
      return c;
   endfunction

   function automatic word_type top_mask(input logic [BITSEL_W-1:0] r);
      return ~({BLOCK_BITS{1'b1}} >> r);
   endfunction

endpackage

`default_nettype wire

/* src/bit_sequence_rank_directory_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// Rank engine over a 64 Kbit sequence held in a 2048 x 32 word memory.
// Request channel (req_valid/req_stall): mode, byte_index, byte_value, position.
//   mode 0 writes one byte, mode 1 builds the superblock count table,
//   mode 2/3 return the count of ones/zeros at or before position.
// Response channel (rsp_valid/rsp_stall): one rank_count beat per request,
//   zero for write and build. The response sits in an output register, so
//   the engine takes the next request while that beat waits on rsp_stall.
// CSR channel (csr_valid/csr_ready, always ready): index 0 superblock factor
//   (0 selects 4), index 1 sequence length. Write only while idle.
// Request paths: a write, or a negative or out-of-range query, goes straight
//   to the final state; a query runs the 12-step divider, then reads the
//   words between superblock start and position, one word read per cycle;
//   build reads one word per cycle over the sequence.
// After reset a clearing pass zeroes the word memory, with req_stall high.
// A stalled response holds the engine in its final state.
module bit_sequence_rank_directory_top
   import bsrd_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [1:0]               req_mode,
   input  wire logic [BIDX_W-1:0]        req_byte_index,
   input  wire logic [BYTE_W-1:0]        req_byte_value,
   input  wire logic signed [POS_W-1:0]  req_position,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [CNT_W-1:0]              rsp_rank_count,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic                     csr_index,
   input  wire logic [CNT_W-1:0]         csr_wdata
);

   localparam logic [2:0] ST_CLR   = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_WALK  = 3'd3;
   localparam logic [2:0] ST_DRAIN = 3'd4;
   localparam logic [2:0] ST_FIN   = 3'd5;

   word_type               word_mem [0:WORD_CNT-1];
   logic [CNT_W-1:0]       tbl_mem  [0:TBL_DEPTH-1];

   logic [2:0]             state_ff, state_in;
   logic [WIDX_W-1:0]      clr_ff, clr_in;
   logic [FACT_W-1:0]      cfg_fact_ff;
   logic [CNT_W-1:0]       cfg_len_ff;
   logic [FACT_W-1:0]      bf_ff, bf_in;
   logic [CNT_W-1:0]       blen_ff, blen_in;
   logic [CNT_W-1:0]       tot_ff, tot_in;
   logic                   bld_ff, bld_in;
   logic                   zero_ff, zero_in;
   logic                   usetot_ff, usetot_in;
   logic                   zrank_ff, zrank_in;
   logic [CNT_W-1:0]       ip1_ff, ip1_in;
   logic [WIDX_W-1:0]      qw_ff, qw_in;
   logic [FACT_W-1:0]      rem_ff, rem_in;
   logic [STEP_W-1:0]      stp_ff, stp_in;
   logic [WIDX_W-1:0]      wend_ff, wend_in;
   logic [BITSEL_W-1:0]    rbits_ff, rbits_in;
   logic [WIDX_W-1:0]      wa_ff, wa_in;
   logic                   p_vld_ff, p_vld_in;
   logic                   p_last_ff, p_last_in;
   logic                   p_oob_ff, p_oob_in;
   word_type               p_mask_ff, p_mask_in;
   logic [CNT_W-1:0]       acc_ff, acc_in;
   logic [FACT_W-1:0]      sbw_ff, sbw_in;
   logic [TBL_AW-1:0]      tk_ff, tk_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]       rsp_cnt_ff, rsp_cnt_in;
   word_type               word_rd_ff;
   logic [CNT_W-1:0]       tbl_rd_ff;

   logic                   wm_we;
   logic [WORD_AW-1:0]     wm_addr;
   logic [LANES-1:0]       wm_be;
   word_type               wm_data;
   logic                   tbl_we;
   logic [TBL_AW-1:0]      tbl_waddr;
   logic [CNT_W-1:0]       tbl_wdata;

   logic                   req_accept;
   logic                   out_free;
   logic [CNT_W-1:0]       pos_u;
   logic [CNT_W-1:0]       len_sat;
   logic [FACT_W-1:0]      fact_eff;
   logic [CNT_W-1:0]       acc_sum;
   logic [FACT_W-1:0]      sbw_nx;
   logic [FACT_W:0]        trial;
   logic                   ge;
   logic [FACT_W-1:0]      rnew;
   logic                   last_w;
   logic [CNT_W-1:0]       ones_val;
   logic [CNT_W-1:0]       result;

   assign req_stall      = (state_ff != ST_IDLE);
   assign req_accept     = req_valid && !req_stall;
   assign out_free       = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_rank_count = rsp_cnt_ff;
   assign csr_ready      = 1'b1;

   assign pos_u    = unsigned'(req_position);
   assign len_sat  = (cfg_len_ff > LEN_MAX) ? LEN_MAX : cfg_len_ff;
   assign fact_eff = (cfg_fact_ff == '0) ? DEF_FACTOR : cfg_fact_ff;
   assign acc_sum  = acc_ff + CNT_W'(popcount32(p_oob_ff ? '0 : (word_rd_ff & p_mask_ff)));
   assign sbw_nx   = sbw_ff + FACT_W'(1);
   assign trial    = {rem_ff, qw_ff[WIDX_W-1]};
   assign ge       = (trial >= {1'b0, bf_ff});
   assign rnew     = ge ? FACT_W'(trial - {1'b0, bf_ff}) : trial[FACT_W-1:0];
   assign last_w   = (wa_ff == wend_ff);
   assign ones_val = usetot_ff ? tot_ff : (tbl_rd_ff + acc_ff);
   assign result   = zero_ff ? '0 : (zrank_ff ? (ip1_ff - ones_val) : ones_val);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      bf_in        = bf_ff;
      blen_in      = blen_ff;
      tot_in       = tot_ff;
      bld_in       = bld_ff;
      zero_in      = zero_ff;
      usetot_in    = usetot_ff;
      zrank_in     = zrank_ff;
      ip1_in       = ip1_ff;
      qw_in        = qw_ff;
      rem_in       = rem_ff;
      stp_in       = stp_ff;
      wend_in      = wend_ff;
      rbits_in     = rbits_ff;
      wa_in        = wa_ff;
      p_vld_in     = 1'b0;
      p_last_in    = p_last_ff;
      p_oob_in     = p_oob_ff;
      p_mask_in    = p_mask_ff;
      acc_in       = acc_ff;
      sbw_in       = sbw_ff;
      tk_in        = tk_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_cnt_in   = rsp_cnt_ff;
      wm_we        = 1'b0;
      wm_addr      = wa_ff[WORD_AW-1:0];
      wm_be        = '0;
      wm_data      = '0;
      tbl_we       = 1'b0;
      tbl_waddr    = tk_ff;
      tbl_wdata    = '0;

      if (p_vld_ff) begin
         acc_in = acc_sum;
         if (bld_ff && !p_last_ff) begin
            if (sbw_nx == bf_ff) begin
               tbl_we    = 1'b1;
               tbl_waddr = tk_ff + TBL_AW'(1);
               tbl_wdata = acc_sum;
               tk_in     = tk_ff + TBL_AW'(1);
               sbw_in    = '0;
            end else begin
               sbw_in = sbw_nx;
            end
         end
      end

      unique case (state_ff)
         ST_CLR: begin
            wm_we   = 1'b1;
            wm_addr = clr_ff[WORD_AW-1:0];
            wm_be   = '1;
            clr_in  = clr_ff + WIDX_W'(1);
            if (clr_ff == WIDX_W'(WORD_CNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               zero_in   = 1'b1;
               usetot_in = 1'b0;
               zrank_in  = (req_mode == MODE_ZEROS);
               bld_in    = 1'b0;
               ip1_in    = pos_u + CNT_W'(1);
               acc_in    = '0;
               unique case (req_mode)
                  MODE_WRITE: begin
                     wm_we    = 1'b1;
                     wm_addr  = req_byte_index[BIDX_W-1:LANE_W];
                     wm_be    = {1'b1, {(LANES-1){1'b0}}} >> req_byte_index[LANE_W-1:0];
                     wm_data  = {LANES{req_byte_value}};
                     state_in = ST_FIN;
                  end
                  MODE_BUILD: begin
                     bf_in     = fact_eff;
                     blen_in   = len_sat;
                     tbl_we    = 1'b1;
                     tbl_waddr = '0;
                     tbl_wdata = '0;
                     wa_in     = '0;
                     wend_in   = len_sat[CNT_W-1:BITSEL_W];
                     rbits_in  = len_sat[BITSEL_W-1:0];
                     sbw_in    = '0;
                     tk_in     = '0;
                     bld_in    = 1'b1;
                     state_in  = ST_WALK;
                  end
                  MODE_ONES, MODE_ZEROS: begin
                     if (req_position[POS_W-1]) begin
                        state_in = ST_FIN;
                     end else if (pos_u >= blen_ff) begin
                        zero_in   = 1'b0;
                        usetot_in = 1'b1;
                        state_in  = ST_FIN;
                     end else begin
                        zero_in  = 1'b0;
                        qw_in    = ip1_in[CNT_W-1:BITSEL_W];
                        wend_in  = ip1_in[CNT_W-1:BITSEL_W];
                        rbits_in = ip1_in[BITSEL_W-1:0];
                        rem_in   = '0;
                        stp_in   = '0;
                        state_in = ST_DIV;
                     end
                  end
                  default: begin
                     state_in = ST_FIN;
                  end
               endcase
            end
         end
         ST_DIV: begin
            qw_in  = {qw_ff[WIDX_W-2:0], ge};
            rem_in = rnew;
            stp_in = stp_ff + STEP_W'(1);
            if (stp_ff == STEP_W'(DIV_STEPS - 1)) begin
               wa_in    = wend_ff - WIDX_W'(rnew);
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            p_vld_in  = 1'b1;
            p_last_in = last_w;
            p_oob_in  = wa_ff[WIDX_W-1];
            p_mask_in = last_w ? top_mask(rbits_ff) : '1;
            wa_in     = wa_ff + WIDX_W'(1);
            if (last_w) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (bld_ff) begin
               tot_in = acc_ff;
            end
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_cnt_in   = result;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wm_we) begin
         for (int l = 0; l < LANES; l++) begin
            if (wm_be[l]) begin
               word_mem[wm_addr][l*BYTE_W +: BYTE_W] <= wm_data[l*BYTE_W +: BYTE_W];
            end
         end
      end
      word_rd_ff <= word_mem[wa_ff[WORD_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[tbl_waddr] <= tbl_wdata;
      end
      tbl_rd_ff <= tbl_mem[qw_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         clr_ff       <= '0;
         cfg_fact_ff  <= DEF_FACTOR;
         cfg_len_ff   <= '0;
         bf_ff        <= DEF_FACTOR;
         blen_ff      <= '0;
         tot_ff       <= '0;
         bld_ff       <= 1'b0;
         stp_ff       <= '0;
         p_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         bf_ff        <= bf_in;
         blen_ff      <= blen_in;
         tot_ff       <= tot_in;
         bld_ff       <= bld_in;
         stp_ff       <= stp_in;
         p_vld_ff     <= p_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_FACTOR: cfg_fact_ff <= csr_wdata[FACT_W-1:0];
               CSR_LENGTH: cfg_len_ff  <= csr_wdata;
               default:    cfg_len_ff  <= cfg_len_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      zero_ff    <= zero_in;
      usetot_ff  <= usetot_in;
      zrank_ff   <= zrank_in;
      ip1_ff     <= ip1_in;
      qw_ff      <= qw_in;
      rem_ff     <= rem_in;
      wend_ff    <= wend_in;
      rbits_ff   <= rbits_in;
      wa_ff      <= wa_in;
      p_last_ff  <= p_last_in;
      p_oob_ff   <= p_oob_in;
      p_mask_ff  <= p_mask_in;
      acc_ff     <= acc_in;
      sbw_ff     <= sbw_in;
      tk_ff      <= tk_in;
      rsp_cnt_ff <= rsp_cnt_in;
   end

   a_div_rem_below_factor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < bf_ff))
      else $error("divider remainder reached the factor");

   a_word_tag_in_walk: assert property (@(posedge clock) disable iff (reset)
      p_vld_ff |-> (state_ff == ST_WALK || state_ff == ST_DRAIN))
      else $error("word data tag outside the walk");

   a_table_write_in_range: assert property (@(posedge clock) disable iff (reset)
      tbl_we |-> (tbl_waddr <= TBL_AW'(TBL_DEPTH - 1)))
      else $error("table write beyond depth");

   a_fin_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && out_free) |=> rsp_valid)
      else $error("final state left without a response beat");

   a_clear_blocks_requests: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLR) |-> (req_stall && !wm_we == 1'b0))
      else $error("request taken during clearing pass");

endmodule

`default_nettype wire

/* bench/tb_bit_sequence_rank_directory_top.sv */
`timescale 1ns / 1ps

module tb_bit_sequence_rank_directory_top
   import bsrd_pkg::*;
();

   localparam int STORE_BYTES    = MAX_BITS / 8;
   localparam int RANDOM_ITEMS   = 1300;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLD_CYCLES    = 400;
   localparam int TAIL_CYCLES    = 300;

   class rank_mirror;
      bit [BYTE_W-1:0] seq_bytes [STORE_BYTES];
      bit [CNT_W-1:0]  sb_counts [TBL_DEPTH];
      bit [CNT_W-1:0]  ones_total;
      int unsigned     built_factor = 4;
      int unsigned     built_length;
      bit [FACT_W-1:0] factor_reg = DEF_FACTOR;
      bit [CNT_W-1:0]  length_reg;
      bit [CNT_W-1:0]  ranks_due [$];
      int              errors;

      function void take_reg(logic index, logic [CNT_W-1:0] data);
         if (index == CSR_FACTOR)
            factor_reg = data[FACT_W-1:0];
         else
            length_reg = data;
      endfunction

      function int unsigned ones_in(int unsigned start, int unsigned n);
         int unsigned c;
         c = 0;
         for (int unsigned k = 0; k < n; k++) begin
            if (((start + k) >> 3) < STORE_BYTES)
               c += seq_bytes[(start + k) >> 3][7 - ((start + k) & 7)];
         end
         return c;
      endfunction

      function bit [CNT_W-1:0] ones_upto(int unsigned pos);
         int unsigned span, i, slot, base;
         span = BLOCK_BITS * built_factor;
         if (pos >= built_length)
            return ones_total;
         i = pos + 1;
         slot = i / span;
         base = slot * span;
         if (slot >= TBL_DEPTH)
            slot = TBL_DEPTH - 1;
         return CNT_W'(sb_counts[slot] + ones_in(base, i - base));
      endfunction

      function void take_request(logic [1:0] mode, logic [BIDX_W-1:0] idx,
                                 logic [BYTE_W-1:0] val, logic [POS_W-1:0] pos);
         int unsigned f, len, span;
         bit [CNT_W-1:0] ones, rank;
         rank = '0;
         case (mode)
            MODE_WRITE: seq_bytes[idx] = val;
            MODE_BUILD: begin
               f = (factor_reg != 0) ? factor_reg : DEF_FACTOR;
               len = (length_reg > MAX_BITS) ? MAX_BITS : length_reg;
               span = BLOCK_BITS * f;
               built_factor = f;
               built_length = len;
               sb_counts[0] = '0;
               for (int unsigned k = 1; k < len / span + 1 && k < TBL_DEPTH; k++)
                  sb_counts[k] = CNT_W'(sb_counts[k-1] + ones_in((k - 1) * span, span));
               ones_total = '0;
               if (len > 0)
                  ones_total = ones_upto(len - 1);
            end
            default: begin
               if (!pos[POS_W-1]) begin
                  ones = ones_upto(pos);
                  rank = (mode == MODE_ONES) ? ones : CNT_W'(pos + 1 - ones);
               end
            end
         endcase
         ranks_due.push_back(rank);
      endfunction

      function void take_rank(logic [CNT_W-1:0] got);
         bit [CNT_W-1:0] want;
         if (ranks_due.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("%0t: rank beat %0d with no request outstanding", $time, got);
         end else begin
            want = ranks_due.pop_front();
            if (got !== want) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: rank_count expected %0d, actual %0d", $time, want, got);
            end
         end
      endfunction

      function int pending();
         return ranks_due.size();
      endfunction
   endclass

   logic                    clock          = 1'b0;
   logic                    reset          = 1'b1;
   logic                    req_valid      = 1'b0;
   logic                    req_stall;
   logic [1:0]              req_mode       = MODE_WRITE;
   logic [BIDX_W-1:0]       req_byte_index = '0;
   logic [BYTE_W-1:0]       req_byte_value = '0;
   logic signed [POS_W-1:0] req_position   = '0;
   logic                    rsp_valid;
   logic                    rsp_stall      = 1'b0;
   logic [CNT_W-1:0]        rsp_rank_count;
   logic                    csr_valid      = 1'b0;
   logic                    csr_ready;
   logic                    csr_index      = CSR_FACTOR;
   logic [CNT_W-1:0]        csr_wdata      = '0;

   bit         hold_rsp;
   int         quiet_cycles;
   int         burst_left;
   rank_mirror mirror = new;

   bit_sequence_rank_directory_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_byte_index (req_byte_index),
      .req_byte_value (req_byte_value),
      .req_position   (req_position),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_rank_count (rsp_rank_count),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            mirror.take_reg(csr_index, csr_wdata);
         if (req_valid && !req_stall)
            mirror.take_request(req_mode, req_byte_index, req_byte_value, req_position);
         if (rsp_valid && !rsp_stall)
            mirror.take_rank(rsp_rank_count);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[bit_sequence_rank_directory_top] ERROR");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      int seg_left;
      int style;
      seg_left = 0;
      style = 0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            // hold off long enough to back the engine up into the request side
            hold_rsp = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            if (seg_left == 0) begin
               style = $urandom_range(0, 3);
               seg_left = $urandom_range(20, 200);
            end
            seg_left--;
            case (style)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= (seg_left % 8 < 3);
            endcase
         end
      end
   end

   task automatic offer_beat(input logic [1:0] mode, input logic [BIDX_W-1:0] idx,
                             input logic [BYTE_W-1:0] val, input logic [POS_W-1:0] pos);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 24);
      end
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_byte_index <= idx;
      req_byte_value <= val;
      req_position   <= pos;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (mirror.pending() != 0) @(posedge clock);
   endtask

   task automatic set_regs(input bit [1:0] sel, input logic [CNT_W-1:0] factor,
                           input logic [CNT_W-1:0] length);
      for (int k = 0; k < 2; k++) begin
         if (sel[k]) begin
            csr_valid <= 1'b1;
            csr_index <= (k == 0) ? CSR_FACTOR : CSR_LENGTH;
            csr_wdata <= (k == 0) ? factor : length;
            @(posedge clock);
            while (!csr_ready) @(posedge clock);
         end
      end
      csr_valid <= 1'b0;
   endtask

   function automatic logic [CNT_W-1:0] pick_factor();
      case ($urandom_range(0, 11))
         0: return '0;
         1: return CNT_W'(1);
         2: return CNT_W'(64);
         3: return CNT_W'(127);
         4: return CNT_W'($urandom_range(65, 127));
         5, 6: return CNT_W'($urandom_range(1, 8));
         default: return CNT_W'($urandom_range(0, 64));
      endcase
   endfunction

   function automatic logic [CNT_W-1:0] pick_length();
      case ($urandom_range(0, 19))
         0: return '0;
         1, 2: return LEN_MAX;
         3: return ($urandom_range(0, 1) == 0) ? 17'h1FFFF
                                                : CNT_W'($urandom_range(65537, 131071));
         4, 5: return CNT_W'($urandom_range(0, 65535));
         6, 7, 8, 9: return CNT_W'($urandom_range(0, 8192));
         default: return CNT_W'($urandom_range(1, 1024));
      endcase
   endfunction

   function automatic logic [BYTE_W-1:0] pick_byte();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'hFF;
         default: return BYTE_W'($urandom);
      endcase
   endfunction

   function automatic logic [POS_W-1:0] pick_position(input int unsigned span,
                                                      input int unsigned sblk);
      int p;
      case ($urandom_range(0, 9))
         0: return {1'b1, 16'($urandom)};
         1: return POS_W'($urandom);
         2: p = span + $urandom_range(0, 3) - 1;
         3: p = $urandom_range(0, span / sblk) * sblk + $urandom_range(0, 2) - 1;
         default: p = $urandom_range(0, span + 8);
      endcase
      if (p < 0)
         return '1;
      if (p > 65535)
         p = 65535;
      return POS_W'(p);
   endfunction

   initial begin
      int unsigned       span, sblk, byte_top, base, nw, nq, r;
      int                sent;
      bit                held;
      bit                seq_run;
      bit [1:0]          sel;
      logic [1:0]        m;
      logic [CNT_W-1:0]  fac_reg, len_reg;
      logic [BIDX_W-1:0] idx;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // nothing built yet, reset registers
      offer_beat(MODE_ONES, '0, '0, 17'd0);
      offer_beat(MODE_ZEROS, '0, '0, 17'd100);
      offer_beat(MODE_ZEROS, '0, '0, 17'd65535);
      offer_beat(MODE_ONES, '0, '0, 17'h1FFFF);
      offer_beat(MODE_ZEROS, '0, '0, 17'h10000);
      offer_beat(MODE_WRITE, 13'd0, 8'hFF, '0);
      offer_beat(MODE_WRITE, 13'h1FFF, 8'h81, '0);
      offer_beat(MODE_WRITE, 13'd5, 8'h5A, '0);
      offer_beat(MODE_BUILD, '0, '0, '0);
      offer_beat(MODE_ONES, '0, '0, 17'd3);
      drain();

      // default factor, length saturated to the full store
      set_regs(2'b11, 17'd0, 17'h1FFFF);
      offer_beat(MODE_BUILD, '0, '0, '0);
      offer_beat(MODE_ONES, '0, '0, 17'd0);
      offer_beat(MODE_ONES, '0, '0, 17'd7);
      offer_beat(MODE_ZEROS, '0, '0, 17'd47);
      offer_beat(MODE_ONES, '0, '0, 17'd65535);
      offer_beat(MODE_ZEROS, '0, '0, 17'd65535);
      offer_beat(MODE_ONES, '0, '0, 17'd65534);
      offer_beat(MODE_WRITE, 13'd0, 8'h0F, '0);
      offer_beat(MODE_ONES, '0, '0, 17'd7);
      drain();

      // new registers without a build keep the latched directory
      set_regs(2'b11, 17'd127, 17'd40);
      offer_beat(MODE_ONES, '0, '0, 17'd39);
      offer_beat(MODE_BUILD, '0, '0, '0);
      offer_beat(MODE_ONES, '0, '0, 17'd39);
      offer_beat(MODE_ZEROS, '0, '0, 17'd40);
      drain();

      set_regs(2'b11, 17'd64, LEN_MAX);
      offer_beat(MODE_BUILD, '0, '0, '0);
      offer_beat(MODE_ONES, '0, '0, 17'd30000);

      fac_reg = CNT_W'(64);
      len_reg = LEN_MAX;
      span = MAX_BITS;
      sblk = BLOCK_BITS * 64;
      sent = 0;
      held = 1'b0;
      while (sent < RANDOM_ITEMS) begin
         drain();
         sel = 2'($urandom_range(1, 3));
         if (sel[0])
            fac_reg = pick_factor();
         if (sel[1])
            len_reg = pick_length();
         set_regs(sel, fac_reg, len_reg);

         byte_top = (len_reg >= MAX_BITS) ? STORE_BYTES - 1 : len_reg / 8;
         base = $urandom_range(0, byte_top);
         seq_run = $urandom_range(0, 1);
         nw = $urandom_range(4, 24);
         for (int k = 0; k < nw; k++) begin
            if ($urandom_range(0, 4) == 0)
               idx = BIDX_W'($urandom);
            else if (seq_run)
               idx = BIDX_W'(base + k);
            else
               idx = BIDX_W'($urandom_range(0, byte_top));
            offer_beat(MODE_WRITE, idx, pick_byte(), POS_W'($urandom));
            sent++;
         end

         if ($urandom_range(0, 6) != 0) begin
            offer_beat(MODE_BUILD, BIDX_W'($urandom), BYTE_W'($urandom), POS_W'($urandom));
            sent++;
            span = (len_reg > MAX_BITS) ? MAX_BITS : len_reg;
            sblk = BLOCK_BITS * ((fac_reg != 0) ? fac_reg : DEF_FACTOR);
         end

         if (!held && sent > 200) begin
            hold_rsp = 1'b1;
            held = 1'b1;
         end

         nq = $urandom_range(15, 50);
         for (int k = 0; k < nq; k++) begin
            r = $urandom_range(0, 99);
            if (r < 70)
               offer_beat(($urandom_range(0, 1) == 0) ? MODE_ONES : MODE_ZEROS,
                          BIDX_W'($urandom), BYTE_W'($urandom), pick_position(span, sblk));
            else if (r < 85)
               offer_beat(MODE_WRITE, BIDX_W'($urandom_range(0, byte_top)), pick_byte(),
                          POS_W'($urandom));
            else begin
               m = (r < 90) ? MODE_BUILD : 2'($urandom);
               offer_beat(m, BIDX_W'($urandom), BYTE_W'($urandom), POS_W'($urandom));
               if (m == MODE_BUILD) begin
                  span = (len_reg > MAX_BITS) ? MAX_BITS : len_reg;
                  sblk = BLOCK_BITS * ((fac_reg != 0) ? fac_reg : DEF_FACTOR);
               end
            end
            sent++;
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mirror.errors == 0 && mirror.pending() == 0)
         $display("[bit_sequence_rank_directory_top] OK");
      else
         $display("[bit_sequence_rank_directory_top] ERROR");
      $finish;
   end

endmodule
